// File: rtl/avp_sd_pkg.sv
// ----------------------------------------------------------------------------
// avp_sd_pkg
// Types and constants shared by the attribute record deframer.
// ----------------------------------------------------------------------------
package avp_sd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [3:0]  BASE_HDR_SIZE   = 4'd8;
  localparam logic [3:0]  VENDOR_HDR_SIZE = 4'd12;
  localparam logic [7:0]  MASK_RESET      = 8'h80;

  localparam logic [1:0]  ROLE_HEADER = 2'd0;
  localparam logic [1:0]  ROLE_VENDOR = 2'd1;
  localparam logic [1:0]  ROLE_DATA   = 2'd2;
  localparam logic [1:0]  ROLE_PAD    = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VENDOR,
    PH_DATA,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic        malformed;
    logic        record_done;
    logic        header_done;
    logic [23:0] payload_length;
    logic [23:0] record_length;
    logic [31:0] vendor_number;
    logic [7:0]  record_flags;
    logic [31:0] record_code;
    logic [7:0]  byte_value;
    logic [1:0]  byte_role;
  } result_t;

endpackage

// File: rtl/avp_sd_fifo.sv
// ----------------------------------------------------------------------------
// avp_sd_fifo
// Front end: accepts stream bytes and queues them for the record parser.
// ----------------------------------------------------------------------------
module avp_sd_fifo (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output logic [7:0] head_data
);
  import avp_sd_pkg::*;

  logic [7:0]         entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  logic do_push;
  logic do_pop;

  assign full       = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/avp_sd_parser.sv
// ----------------------------------------------------------------------------
// avp_sd_parser
// Back end: walks header, vendor id, data and padding of each record and
// registers one tagged result per byte.
// ----------------------------------------------------------------------------
module avp_sd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          vendor_flag_mask,
  input  logic                head_valid,
  input  logic [7:0]          head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output avp_sd_pkg::result_t out_result
);
  import avp_sd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hpos, hpos_next;
  logic [31:0] code, code_next;
  logic [7:0]  flags, flags_next;
  logic [23:0] length, length_next;
  logic [31:0] vendor, vendor_next;
  logic [23:0] data_rem, data_rem_next;
  logic [1:0]  pad_rem, pad_rem_next;
  logic [23:0] payload, payload_next;
  logic        bad, bad_next;
  logic        hdone, rdone;
  logic [1:0]  role;

  logic        fire;
  logic [3:0]  hp;
  logic [3:0]  hp_inc;
  logic        clr;
  logic [23:0] close_len;
  logic [23:0] close_size;
  logic        close_short;
  logic [23:0] close_pay;
  logic [23:0] dr_dec;
  logic [1:0]  pr_dec;
  result_t     result;

  assign fire = head_valid && (!out_valid || out_ready);
  assign pop  = fire;

  // Header position wraps back to the first byte once past the base header
  assign hp     = (hpos >= BASE_HDR_SIZE) ? 4'd0 : hpos;
  assign hp_inc = ((phase == PH_VENDOR) ? hpos : hp) + 4'd1;
  assign clr    = (hp == 4'd0);
  assign dr_dec = data_rem - 24'd1;
  assign pr_dec = pad_rem - 2'd1;

  // A header can only close on its last byte, so the length is final here
  assign close_len   = (phase == PH_VENDOR) ? length : {length[15:0], head_data};
  assign close_size  = (phase == PH_VENDOR) ? 24'(VENDOR_HDR_SIZE) : 24'(BASE_HDR_SIZE);
  assign close_short = (close_len < close_size);
  assign close_pay   = close_short ? 24'd0 : (close_len - close_size);

  // Next state and record registers
  always_comb begin
    phase_next    = phase;
    hpos_next     = hpos;
    code_next     = code;
    flags_next    = flags;
    length_next   = length;
    vendor_next   = vendor;
    data_rem_next = data_rem;
    pad_rem_next  = pad_rem;
    payload_next  = payload;
    bad_next      = bad;
    hdone         = 1'b0;
    rdone         = 1'b0;
    unique case (phase)
      PH_VENDOR: begin
        vendor_next = {vendor[23:0], head_data};
        hpos_next   = hp_inc;
        if (hp_inc >= VENDOR_HDR_SIZE) begin
          hdone         = 1'b1;
          bad_next      = close_short;
          payload_next  = close_pay;
          data_rem_next = close_pay;
          pad_rem_next  = 2'(2'd0 - close_pay[1:0]);
          hpos_next     = 4'd0;
          if (close_pay != 24'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_HEADER;
            rdone      = 1'b1;
          end
        end
      end
      PH_DATA: begin
        data_rem_next = dr_dec;
        if (dr_dec == 24'd0) begin
          if (pad_rem != 2'd0) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_HEADER;
            rdone      = 1'b1;
          end
        end
      end
      PH_PAD: begin
        pad_rem_next = pr_dec;
        if (pr_dec == 2'd0) begin
          phase_next = PH_HEADER;
          rdone      = 1'b1;
        end
      end
      PH_HEADER: begin
        if (clr) begin
          code_next    = '0;
          flags_next   = '0;
          length_next  = '0;
          vendor_next  = '0;
          payload_next = '0;
          bad_next     = 1'b0;
        end
        if (hp < 4'd4) begin
          code_next = {(clr ? 24'd0 : code[23:0]), head_data};
        end else if (hp == 4'd4) begin
          flags_next = head_data;
        end else begin
          length_next = {length[15:0], head_data};
        end
        hpos_next = hp_inc;
        if (hp_inc == BASE_HDR_SIZE) begin
          if ((flags & vendor_flag_mask) != 8'd0) begin
            phase_next = PH_VENDOR;
          end else begin
            hdone         = 1'b1;
            bad_next      = close_short;
            payload_next  = close_pay;
            data_rem_next = close_pay;
            pad_rem_next  = 2'(2'd0 - close_pay[1:0]);
            hpos_next     = 4'd0;
            if (close_pay != 24'd0) begin
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_HEADER;
              rdone      = 1'b1;
            end
          end
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  // Role tag from the phase the byte arrives in
  always_comb begin
    unique case (phase)
      PH_HEADER: role = ROLE_HEADER;
      PH_VENDOR: role = ROLE_VENDOR;
      PH_DATA:   role = ROLE_DATA;
      PH_PAD:    role = ROLE_PAD;
      default:   role = ROLE_HEADER;
    endcase
  end

  always_comb begin
    result.byte_role      = role;
    result.byte_value     = head_data;
    result.record_code    = code_next;
    result.record_flags   = flags_next;
    result.vendor_number  = vendor_next;
    result.record_length  = length_next;
    result.payload_length = payload_next;
    result.header_done    = hdone;
    result.record_done    = rdone;
    result.malformed      = bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      hpos     <= '0;
      code     <= '0;
      flags    <= '0;
      length   <= '0;
      vendor   <= '0;
      data_rem <= '0;
      pad_rem  <= '0;
      payload  <= '0;
      bad      <= 1'b0;
    end else if (fire) begin
      phase    <= phase_next;
      hpos     <= hpos_next;
      code     <= code_next;
      flags    <= flags_next;
      length   <= length_next;
      vendor   <= vendor_next;
      data_rem <= data_rem_next;
      pad_rem  <= pad_rem_next;
      payload  <= payload_next;
      bad      <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_vendor_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VENDOR) |-> (hpos >= BASE_HDR_SIZE) && (hpos < VENDOR_HDR_SIZE))
    else $error("vendor phase with header position out of range");
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_rem != 24'd0))
    else $error("data phase with no data left");
  a_pad_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> (pad_rem != 2'd0))
    else $error("pad phase with no padding left");
  a_short_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.header_done && out_result.malformed)
      |-> out_result.record_done)
    else $error("malformed record did not end on its header");
`endif

endmodule

// File: rtl/avp_stream_deframer_core.sv
// ----------------------------------------------------------------------------
// avp_stream_deframer_core
// Splits a byte stream into attribute-value records, one tagged result a byte.
// ----------------------------------------------------------------------------
// Each byte passes through the queue and the parser output register before its result is valid.
// Throughput: one byte per cycle while the result stream is not stalled;
//   a four-entry queue lets input and output stall independently.
// Reset: clears the queue, output valid flag and record state; the parser
//   expects header byte zero and vendor_flag_mask returns to 0x80.
module avp_stream_deframer_core (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel: vendor_flag_mask
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // stream_byte
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // byte_value, record_code, record_flags, vendor_number, record_length,
  // payload_length
  output logic [127:0] m_axis_tdata,
  // byte_role, header_done, malformed
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast    // record_done
);
  import avp_sd_pkg::*;

  logic [7:0] mask;
  logic       full;
  logic       head_valid;
  logic [7:0] head_data;
  logic       pop;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask <= cfg_data;
    end
  end

  assign s_axis_tready = !full;

  avp_sd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid),
    .push_data  (s_axis_tdata),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  avp_sd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .vendor_flag_mask (mask),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_result       (res)
  );

  assign m_axis_tdata = {res.payload_length, res.record_length, res.vendor_number,
                         res.record_flags, res.record_code, res.byte_value};
  assign m_axis_tuser = {res.malformed, res.header_done, res.byte_role};
  assign m_axis_tlast = res.record_done;

endmodule
